[hdl/latin_square_trace_and_repeat_check_assert.svh]
// Assertion macros shared by the checker RTL.
`ifndef LATIN_SQUARE_TRACE_AND_REPEAT_CHECK_ASSERT_SVH
`define LATIN_SQUARE_TRACE_AND_REPEAT_CHECK_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define LSQ_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("lsq assertion failed");
// next-cycle implication
`define LSQ_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("lsq assertion failed");
`else
`define LSQ_ASSERT_IMP(label, clk, rstn, ante, cons)
`define LSQ_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif

`endif

[hdl/lsq_pkg.sv]
package lsq_pkg;

    localparam int MAX_N   = 64;             // largest value tracked in a bitmap
    localparam int BMP_W   = MAX_N;          // bitmap width
    localparam int DIM_MAX = 64;             // largest side length
    localparam int POS_W   = $clog2(DIM_MAX);
    localparam int SIZE_W  = 7;
    localparam int VAL_W   = 7;
    localparam int TRACE_W = 13;
    localparam int CNT_W   = 7;
    localparam int DATA_IN_W  = 8;
    localparam int DATA_OUT_W = 32;
    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(4);

    // one element on its way from the position counters to the check stage
    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [POS_W-1:0] col;
        logic             row0;
        logic             diag;
        logic             end_row;
        logic             end_mat;
    } item_t;

    // one column entry of the bitmap memory
    typedef struct packed {
        logic             rep;
        logic [BMP_W-1:0] seen;
    } col_word_t;

    typedef struct packed {
        logic [CNT_W-1:0]   cols;
        logic [CNT_W-1:0]   rows;
        logic [TRACE_W-1:0] trace;
    } result_t;

    // one-hot mark for a value; zero and values above MAX_N mark nothing
    function automatic logic [BMP_W-1:0] value_bit(input logic [VAL_W-1:0] v);
        logic [BMP_W-1:0] b;
        b = '0;
        if (v != VAL_W'(0) && int'(v) <= MAX_N) begin
            b = BMP_W'(1) << (v - VAL_W'(1));
        end
        return b;
    endfunction

endpackage

[hdl/latin_square_trace_and_repeat_check.sv]
// Latin-square checker with trace. Send the n*n elements of a matrix in
// row-major order, one per s_ beat; on the last element one m_ beat carries
// the diagonal sum, the number of rows holding a repeated value and the number
// of columns holding one. The block takes one beat per clock cycle unless a
// last element is held. The result is registered in an output register when
// the last element leaves the p1 stage, so input keeps flowing while it waits,
// up to the last element of the next matrix, which is held until the result
// is taken. Throughput is set by the column bitmap memory, which sees one read
// and one write per element (read at accept, write as the element leaves the
// p1 stage). The memory needs no clearing pass: row 0 of every matrix rewrites
// each column entry. Writing cfg_wr_data (side length n, 0 taken as 1, above 64
// taken as 64) restarts at row 0, column 0; write it only when the block is idle.
`include "latin_square_trace_and_repeat_check_assert.svh"

module latin_square_trace_and_repeat_check (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [lsq_pkg::SIZE_W-1:0]       cfg_wr_data,   // matrix_size
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [lsq_pkg::DATA_IN_W-1:0]    s_tdata,       // [6:0] value, [7] zero
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [lsq_pkg::DATA_OUT_W-1:0]   m_tdata        // [12:0] trace,
                                                            // [19:13] repeated_rows,
                                                            // [26:20] repeated_cols,
                                                            // [31:27] zero
);
    import lsq_pkg::*;

    logic            s_accept;
    logic [POS_W-1:0] rd_col;
    logic            p1_valid;
    item_t           p1_item;
    logic            p1_adv;
    result_t         result;
    logic            m_valid_reg, m_valid_next;
    result_t         m_data_reg;

    // hold the last element while a previous result is still waiting
    assign p1_adv = p1_valid && (!p1_item.end_mat || !m_valid_reg || m_tready);

    lsq_pos u_pos (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_value     (s_tdata[VAL_W-1:0]),
        .p1_adv      (p1_adv),
        .s_accept    (s_accept),
        .rd_col      (rd_col),
        .p1_valid    (p1_valid),
        .p1_item     (p1_item)
    );

    lsq_check u_check (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .restart  (cfg_wr_en),
        .s_accept (s_accept),
        .rd_col   (rd_col),
        .p1_adv   (p1_adv),
        .p1_item  (p1_item),
        .result   (result)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (p1_adv && p1_item.end_mat) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_adv && p1_item.end_mat) begin
            m_data_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = DATA_OUT_W'(m_data_reg);

    `LSQ_ASSERT_NXT(a_result_shown, aclk, aresetn, p1_adv && p1_item.end_mat, m_tvalid)
    `LSQ_ASSERT_IMP(a_ready_when_empty, aclk, aresetn, !p1_valid, s_tready)

endmodule

[hdl/lsq_pos.sv]
`include "latin_square_trace_and_repeat_check_assert.svh"

module lsq_pos (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [lsq_pkg::SIZE_W-1:0]  cfg_wr_data,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [lsq_pkg::VAL_W-1:0]   s_value,
    input  logic                        p1_adv,
    output logic                        s_accept,
    output logic [lsq_pkg::POS_W-1:0]   rd_col,
    output logic                        p1_valid,
    output lsq_pkg::item_t              p1_item
);
    import lsq_pkg::*;

    logic [SIZE_W-1:0] size_reg;
    logic [POS_W-1:0]  col_pos_reg, col_pos_next;
    logic [POS_W-1:0]  row_pos_reg, row_pos_next;
    logic              p1_valid_reg, p1_valid_next;
    item_t             p1_item_reg, p1_item_next;
    logic [SIZE_W-1:0] side;
    logic              last_col, last_row;

    always_comb begin
        if (size_reg == SIZE_W'(0)) begin
            side = SIZE_W'(1);
        end else if (size_reg > SIZE_W'(DIM_MAX)) begin
            side = SIZE_W'(DIM_MAX);
        end else begin
            side = size_reg;
        end
    end

    assign last_col = (SIZE_W'(col_pos_reg) + SIZE_W'(1)) == side;
    assign last_row = (SIZE_W'(row_pos_reg) + SIZE_W'(1)) == side;

    assign s_tready = !p1_valid_reg || p1_adv;
    assign s_accept = s_tvalid && s_tready;
    assign rd_col   = col_pos_reg;

    always_comb begin
        col_pos_next  = col_pos_reg;
        row_pos_next  = row_pos_reg;
        p1_valid_next = p1_valid_reg;
        p1_item_next  = p1_item_reg;
        if (p1_adv) begin
            p1_valid_next = 1'b0;
        end
        if (s_accept) begin
            p1_valid_next        = 1'b1;
            p1_item_next.value   = s_value;
            p1_item_next.col     = col_pos_reg;
            p1_item_next.row0    = (row_pos_reg == '0);
            p1_item_next.diag    = (row_pos_reg == col_pos_reg);
            p1_item_next.end_row = last_col;
            p1_item_next.end_mat = last_col && last_row;
            if (last_col) begin
                col_pos_next = '0;
                row_pos_next = last_row ? '0 : row_pos_reg + POS_W'(1);
            end else begin
                col_pos_next = col_pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg     <= SIZE_RESET;
            col_pos_reg  <= '0;
            row_pos_reg  <= '0;
            p1_valid_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            // abandon the current matrix
            size_reg     <= cfg_wr_data;
            col_pos_reg  <= '0;
            row_pos_reg  <= '0;
            p1_valid_reg <= p1_valid_next;
        end else begin
            col_pos_reg  <= col_pos_next;
            row_pos_reg  <= row_pos_next;
            p1_valid_reg <= p1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        p1_item_reg <= p1_item_next;
    end

    assign p1_valid = p1_valid_reg;
    assign p1_item  = p1_item_reg;

    `LSQ_ASSERT_IMP(a_col_in_range, aclk, aresetn, 1'b1, SIZE_W'(col_pos_reg) < side)

endmodule

[hdl/lsq_check.sv]
`include "latin_square_trace_and_repeat_check_assert.svh"

module lsq_check (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        restart,
    input  logic                        s_accept,
    input  logic [lsq_pkg::POS_W-1:0]   rd_col,
    input  logic                        p1_adv,
    input  lsq_pkg::item_t              p1_item,
    output lsq_pkg::result_t            result
);
    import lsq_pkg::*;

    col_word_t          col_mem [DIM_MAX];
    col_word_t          rd_reg;
    col_word_t          wr_word;
    logic [BMP_W-1:0]   row_seen_reg, row_seen_next;
    logic               row_rep_reg, row_rep_next;
    logic [TRACE_W-1:0] trace_reg, trace_next;
    logic [CNT_W-1:0]   bad_row_reg, bad_row_next;
    logic [CNT_W-1:0]   bad_col_reg, bad_col_next;
    logic [BMP_W-1:0]   bit_v;
    logic               row_rep_now, col_hit, col_inc;

    always_comb begin
        bit_v       = value_bit(p1_item.value);
        row_rep_now = row_rep_reg || (|(row_seen_reg & bit_v));
        col_hit     = |(rd_reg.seen & bit_v);
        if (p1_item.row0) begin
            // first row rewrites the column entry
            wr_word.seen = bit_v;
            wr_word.rep  = 1'b0;
            col_inc      = 1'b0;
        end else begin
            wr_word.seen = rd_reg.seen | bit_v;
            wr_word.rep  = rd_reg.rep | col_hit;
            col_inc      = col_hit && !rd_reg.rep;
        end
        trace_next    = trace_reg + (p1_item.diag ? TRACE_W'(p1_item.value) : TRACE_W'(0));
        bad_row_next  = bad_row_reg + CNT_W'(p1_item.end_row && row_rep_now);
        bad_col_next  = bad_col_reg + CNT_W'(col_inc);
        row_seen_next = p1_item.end_row ? '0 : (row_seen_reg | bit_v);
        row_rep_next  = p1_item.end_row ? 1'b0 : row_rep_now;
    end

    assign result.trace = trace_next;
    assign result.rows  = bad_row_next;
    assign result.cols  = bad_col_next;

    // a column is read again only a full row later, after its write
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            rd_reg <= col_mem[rd_col];
        end
        if (p1_adv) begin
            col_mem[p1_item.col] <= wr_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            row_seen_reg <= '0;
            row_rep_reg  <= 1'b0;
            trace_reg    <= '0;
            bad_row_reg  <= '0;
            bad_col_reg  <= '0;
        end else if (p1_adv) begin
            if (p1_item.end_mat) begin
                row_seen_reg <= '0;
                row_rep_reg  <= 1'b0;
                trace_reg    <= '0;
                bad_row_reg  <= '0;
                bad_col_reg  <= '0;
            end else begin
                row_seen_reg <= row_seen_next;
                row_rep_reg  <= row_rep_next;
                trace_reg    <= trace_next;
                bad_row_reg  <= bad_row_next;
                bad_col_reg  <= bad_col_next;
            end
        end
    end

    `LSQ_ASSERT_IMP(a_rows_bound, aclk, aresetn, 1'b1, bad_row_reg <= CNT_W'(DIM_MAX))
    `LSQ_ASSERT_IMP(a_cols_bound, aclk, aresetn, 1'b1, bad_col_reg <= CNT_W'(DIM_MAX))

endmodule
